>>> sv/assert_macros.svh
// Assertion macros shared by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds on a rising edge of clk outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/mta_pkg.sv
// Shared types, widths, register codes and reset values of the motion trail accumulator
package mta_pkg;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    localparam int PIX_W      = 8;
    localparam int IDX_W      = 19;
    localparam int GAIN_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int GAIN_SHIFT = 12;
    localparam int DIFF_W     = PIX_W + 1;
    localparam int PROD_W     = 22;
    localparam int SUM_W      = 23;
    localparam int PIX_MAX    = 255;

    localparam int QUEUE_DEPTH  = 2;
    localparam int RESULT_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLICKER_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTEN_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARKEN_GAIN       = 2'd3;

    localparam logic [PIX_W-1:0]  MOVE_THRESHOLD_RST    = 8'd0;
    localparam logic [PIX_W-1:0]  FLICKER_THRESHOLD_RST = 8'd0;
    localparam logic [GAIN_W-1:0] BRIGHTEN_GAIN_RST     = 13'd410;
    localparam logic [GAIN_W-1:0] DARKEN_GAIN_RST       = 13'd328;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROCESS = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0]  move_threshold;
        logic [PIX_W-1:0]  flicker_threshold;
        logic [GAIN_W-1:0] brighten_gain;
        logic [GAIN_W-1:0] darken_gain;
    } cfg_t;

    typedef struct packed {
        logic             action;
        logic             in_range;
        logic             motion;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] bg;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             motion;
        logic [IDX_W-1:0] idx;
    } result_t;

endpackage

>>> sv/mta_fifo.sv
// Small register queue with push/full and pop/empty sides
module mta_fifo import mta_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    always_comb
    begin
        full    = (count_reg == CW'(DEPTH));
        empty   = (count_reg == '0);
        push_ok = push && !full;
        pop_ok  = pop && !empty;
        rdata   = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/mta_front.sv
// Front end: accept input words and classify them for the back end
module mta_front import mta_pkg::*;
#(
    parameter int STORE_DEPTH = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF
)
(
    input  cfg_t             cfg,
    input  logic             push,
    input  logic             action,
    input  logic [IDX_W-1:0] pixel_index,
    input  logic [PIX_W-1:0] source_pixel,
    input  logic [PIX_W-1:0] background_pixel,
    input  logic             q_full,
    output logic             q_push,
    output item_t            q_item
);

    logic [PIX_W-1:0] abs_diff;

    always_comb
    begin
        abs_diff = (source_pixel > background_pixel) ? source_pixel - background_pixel
                                                     : background_pixel - source_pixel;
        q_item.action   = action;
        q_item.in_range = (32'(pixel_index) < 32'(STORE_DEPTH));
        q_item.motion   = (action == ACT_PROCESS) && (abs_diff > cfg.move_threshold)
                          && (source_pixel > cfg.flicker_threshold);
        q_item.idx      = pixel_index;
        q_item.src      = source_pixel;
        q_item.bg       = background_pixel;
        q_push          = push && !q_full;
    end

endmodule

>>> sv/mta_back.sv
// Back end: frame store read-modify-write, blend multiply and clamp
module mta_back import mta_pkg::*;
#(
    parameter int STORE_DEPTH = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   q_item,
    input  logic    q_empty,
    output logic    q_pop,
    output result_t res,
    output logic    res_push,
    input  logic    res_full
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [PIX_W-1:0] mem [STORE_DEPTH];

    logic              advance;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [PIX_W-1:0]  rd_data_reg;

    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [PIX_W-1:0]  stored;
    logic signed [DIFF_W-1:0] diff;
    logic [GAIN_W-1:0] gain;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod_next;
    logic [PIX_W-1:0]  base_next;

    logic              c_valid_reg;
    item_t             c_item_reg;
    logic [PIX_W-1:0]  c_base_reg;
    logic signed [PROD_W-1:0] c_prod_reg;
    logic signed [SUM_W-1:0]  sum;
    logic [PIX_W-1:0]  blended;
    logic [PIX_W-1:0]  c_pixel;
    logic              c_write;
    logic              mem_we;

    logic              lw_valid_reg;
    logic [IDX_W-1:0]  lw_idx_reg;
    logic [PIX_W-1:0]  lw_data_reg;

    always_comb
    begin
        advance = !c_valid_reg || !res_full;
        q_pop   = advance && !q_empty;
        rd_en   = q_pop && q_item.in_range;
        rd_addr = AW'(q_item.idx);
    end

    // newest pending write wins over the store's registered read
    always_comb
    begin
        if (c_write && (c_item_reg.idx == b_item_reg.idx))
        begin
            stored = c_pixel;
        end
        else if (lw_valid_reg && (lw_idx_reg == b_item_reg.idx))
        begin
            stored = lw_data_reg;
        end
        else
        begin
            stored = rd_data_reg;
        end

        diff      = signed'({1'b0, b_item_reg.src}) - signed'({1'b0, stored});
        gain      = diff[DIFF_W-1] ? cfg.darken_gain : cfg.brighten_gain;
        diff_ext  = {{(PROD_W - DIFF_W){diff[DIFF_W-1]}}, diff};
        gain_ext  = signed'({{(PROD_W - GAIN_W){1'b0}}, gain});
        prod_next = diff_ext * gain_ext;

        if (!b_item_reg.in_range)
        begin
            base_next = '0;
        end
        else if (b_item_reg.action == ACT_LOAD)
        begin
            base_next = b_item_reg.bg;
        end
        else
        begin
            base_next = stored;
        end
    end

    always_comb
    begin
        sum = signed'({{(SUM_W - PIX_W - GAIN_SHIFT){1'b0}}, c_base_reg, {GAIN_SHIFT{1'b0}}})
              + {{(SUM_W - PROD_W){c_prod_reg[PROD_W-1]}}, c_prod_reg};
        if (sum[SUM_W-1])
        begin
            blended = '0;
        end
        else if (sum > signed'(SUM_W'(PIX_MAX << GAIN_SHIFT)))
        begin
            blended = PIX_W'(PIX_MAX);
        end
        else
        begin
            blended = sum[GAIN_SHIFT + PIX_W - 1:GAIN_SHIFT];
        end
        c_pixel  = (c_item_reg.motion && c_item_reg.in_range) ? blended : c_base_reg;
        c_write  = c_valid_reg && c_item_reg.in_range
                   && ((c_item_reg.action == ACT_LOAD) || c_item_reg.motion);
        mem_we   = c_write && advance;
        res_push = c_valid_reg && advance;
        res.pixel  = c_pixel;
        res.motion = c_item_reg.motion && c_item_reg.in_range;
        res.idx    = c_item_reg.idx;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[AW'(c_item_reg.idx)] <= c_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                b_valid_reg <= q_pop;
                c_valid_reg <= b_valid_reg;
            end
            if (mem_we)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_item_reg <= q_item;
        end
        if (advance)
        begin
            c_item_reg <= b_item_reg;
            c_base_reg <= base_next;
            c_prod_reg <= prod_next;
        end
        if (mem_we)
        begin
            lw_idx_reg  <= c_item_reg.idx;
            lw_data_reg <= c_pixel;
        end
    end

endmodule

>>> sv/motion_trail_accumulator.sv
// Top level of the motion trail accumulator: config registers, front, queues and back end
//
// Input channel: drive action, pixel_index, source_pixel and background_pixel with push;
// a word is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low, pixel_out, motion_seen and index_out show the
// oldest result; it is taken at an edge where pop is high.
// Configuration: cfg_write with cfg_index and cfg_data writes one register at that edge.
// Path: input queue, store read register, blend register, then result queue.
// Throughput: one word per cycle when not stalled, set by the single read and single write
// port of the frame store; a stored pixel written by the previous word is forwarded around
// the store's registered read, so words to the same pixel follow back to back.
// Reset: clears the queues, the pipeline and the registers to their defaults; the frame
// store is not cleared and an entry reads undefined until loaded.
// Stall: when pop stays low the result queue fills, the back end holds, the middle queue
// fills and full rises; no word is lost.
module motion_trail_accumulator import mta_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  action,
    input  logic [IDX_W-1:0]      pixel_index,
    input  logic [PIX_W-1:0]      source_pixel,
    input  logic [PIX_W-1:0]      background_pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  motion_seen,
    output logic [IDX_W-1:0]      index_out
);

    `include "assert_macros.svh"

    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

    cfg_t    cfg_reg, cfg_next;
    logic    q_push;
    logic    q_full;
    item_t   q_wr_item;
    item_t   q_rd_item;
    logic    q_pop;
    logic    q_empty;
    result_t res;
    logic    res_push;
    logic    res_full;
    result_t res_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_MOVE_THRESHOLD:    cfg_next.move_threshold    = cfg_data[PIX_W-1:0];
                REG_FLICKER_THRESHOLD: cfg_next.flicker_threshold = cfg_data[PIX_W-1:0];
                REG_BRIGHTEN_GAIN:     cfg_next.brighten_gain     = cfg_data[GAIN_W-1:0];
                REG_DARKEN_GAIN:       cfg_next.darken_gain       = cfg_data[GAIN_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_threshold    <= MOVE_THRESHOLD_RST;
            cfg_reg.flicker_threshold <= FLICKER_THRESHOLD_RST;
            cfg_reg.brighten_gain     <= BRIGHTEN_GAIN_RST;
            cfg_reg.darken_gain       <= DARKEN_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mta_front #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_front (
        .cfg              (cfg_reg),
        .push             (push),
        .action           (action),
        .pixel_index      (pixel_index),
        .source_pixel     (source_pixel),
        .background_pixel (background_pixel),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (q_wr_item)
    );

    mta_fifo #(
        .WIDTH($bits(item_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wr_item),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rd_item),
        .empty (q_empty)
    );

    mta_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (q_rd_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .res      (res),
        .res_push (res_push),
        .res_full (res_full)
    );

    mta_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(RESULT_DEPTH)
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign full        = q_full;
    assign pixel_out   = res_out.pixel;
    assign motion_seen = res_out.motion;
    assign index_out   = res_out.idx;

    `ASSERT_NEVER(a_result_overflow, res_push && res_full, "result pushed into full queue")
    `ASSERT_CLK(a_motion_in_range, (!empty && motion_seen) |-> (32'(index_out) < 32'(STORE_DEPTH)), "motion flagged outside the frame")
    `ASSERT_CLK(a_outside_zero, (!empty && (32'(index_out) >= 32'(STORE_DEPTH))) |-> (pixel_out == '0), "pixel outside the frame not zero")
    `ASSERT_CLK(a_pop_before_push, (q_pop && !q_empty) |=> !(res_push && res_full), "back end advanced into a stall")

endmodule

>>> verif/tb.sv
// Self-checking testbench for the motion trail accumulator
`timescale 1ns / 100ps

module tb;
    import mta_pkg::*;

    localparam int FRAME_PIXELS = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF;
    localparam int LAST_INDEX   = (1 << IDX_W) - 1;
    localparam int HOT_COUNT    = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct {
        logic             action;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] bg;
    } pix_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MOVE_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  action = ACT_LOAD;
    logic [IDX_W-1:0]      pixel_index = '0;
    logic [PIX_W-1:0]      source_pixel = '0;
    logic [PIX_W-1:0]      background_pixel = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  motion_seen;
    logic [IDX_W-1:0]      index_out;

    pix_word_t  camera_words[$];
    result_t    trail_results[$];
    logic [7:0] trail[int];
    bit         loaded[int];
    int         hot_pixels[HOT_COUNT];

    int move_thr;
    int flicker_thr;
    int brighten_gain;
    int darken_gain;

    int errors = 0;
    int cycles = 0;
    int words_sent = 0;
    int loads_sent = 0;
    int motion_hits = 0;
    int off_frame = 0;
    int results_seen = 0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int mode_age = 0;

    motion_trail_accumulator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .action           (action),
        .pixel_index      (pixel_index),
        .source_pixel     (source_pixel),
        .background_pixel (background_pixel),
        .empty            (empty),
        .pop              (pop),
        .pixel_out        (pixel_out),
        .motion_seen      (motion_seen),
        .index_out        (index_out)
    );

    always #2 clk = ~clk;

    function automatic result_t accumulate_pixel(pix_word_t w);
        result_t r;
        int      stored;
        int      delta;
        int      diff;
        int      gain;
        int      total;
        r.pixel  = '0;
        r.motion = 1'b0;
        r.idx    = w.idx;
        if (int'(w.idx) < FRAME_PIXELS) begin
            if (w.action == ACT_LOAD) begin
                trail[w.idx] = w.bg;
                r.pixel = w.bg;
            end
            else begin
                stored = trail.exists(w.idx) ? int'(trail[w.idx]) : 0;
                delta  = int'(w.src) - int'(w.bg);
                if (delta < 0)
                    delta = -delta;
                r.pixel = stored[7:0];
                if (delta > move_thr && int'(w.src) > flicker_thr) begin
                    diff  = int'(w.src) - stored;
                    gain  = (diff < 0) ? darken_gain : brighten_gain;
                    total = stored * 4096 + diff * gain;
                    if (total > PIX_MAX * 4096)
                        r.pixel = 8'd255;
                    else if (total < 0)
                        r.pixel = 8'd0;
                    else
                        r.pixel = 8'(total / 4096);
                    trail[w.idx] = r.pixel;
                    r.motion = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        pix_word_t w;
        logic      taken;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                w.action = action;
                w.idx    = pixel_index;
                w.src    = source_pixel;
                w.bg     = background_pixel;
                trail_results.push_back(accumulate_pixel(w));
                words_sent++;
                if (int'(w.idx) >= FRAME_PIXELS)
                    off_frame++;
                else if (w.action == ACT_LOAD)
                    loads_sent++;
                if (trail_results[$].motion)
                    motion_hits++;
            end
            if (push && !taken)
            begin
                // hold the word until it is taken
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (camera_words.size() == 0)
            begin
                push <= 1'b0;
            end
            else
            begin
                w = camera_words.pop_front();
                push             <= 1'b1;
                action           <= w.action;
                pixel_index      <= w.idx;
                source_pixel     <= w.src;
                background_pixel <= w.bg;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: stall pattern switches between free flow, coin flips and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (mode_age == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_age   <= $urandom_range(32, 256);
            end
            else
            begin
                mode_age <= mode_age - 1;
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                pop <= 1'b0;
            end
            else if (stall_mode == 0)
            begin
                pop <= 1'b1;
            end
            else if (stall_mode == 1)
            begin
                pop <= 1'($urandom_range(0, 1));
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(1, 24);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // monitor: compare each popped word with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (trail_results.size() == 0)
            begin
                report_mismatch("unexpected result, index", int'(index_out), -1);
            end
            else
            begin
                want = trail_results.pop_front();
                if (pixel_out !== want.pixel)
                    report_mismatch("pixel_out", int'(pixel_out), int'(want.pixel));
                if (motion_seen !== want.motion)
                    report_mismatch("motion_seen", int'(motion_seen), int'(want.motion));
                if (index_out !== want.idx)
                    report_mismatch("index_out", int'(index_out), int'(want.idx));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit with %0d results outstanding",
                     trail_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_word(logic act, int idx, int src, int bg);
        pix_word_t w;
        w.action = act;
        w.idx    = idx[IDX_W-1:0];
        w.src    = src[PIX_W-1:0];
        w.bg     = bg[PIX_W-1:0];
        if (act == ACT_LOAD && idx < FRAME_PIXELS)
            loaded[idx] = 1'b1;
        camera_words.push_back(w);
    endtask

    task automatic program_regs(int m, int f, int b, int d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MOVE_THRESHOLD;
        cfg_data  <= m[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= REG_FLICKER_THRESHOLD;
        cfg_data  <= f[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= REG_BRIGHTEN_GAIN;
        cfg_data  <= b[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= REG_DARKEN_GAIN;
        cfg_data  <= d[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        move_thr      = m;
        flicker_thr   = f;
        brighten_gain = b;
        darken_gain   = d;
    endtask

    task automatic wait_drained();
        while (camera_words.size() != 0 || push || trail_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return PIX_MAX;
        return $urandom_range(0, PIX_MAX);
    endfunction

    function automatic int pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return PIX_MAX;
        if (r < 4)
            return 0;
        if (r < 8)
            return $urandom_range(0, 40);
        return $urandom_range(0, PIX_MAX);
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 4096;
        if (r == 2)
            return 8191;
        if (r == 3)
            return $urandom_range(4097, 8191);
        return $urandom_range(0, 4096);
    endfunction

    task automatic add_random_word();
        int r;
        int idx;
        int src;
        int bg;
        r   = $urandom_range(0, 99);
        src = pick_level();
        bg  = pick_level();
        if (r < 8)
        begin
            idx = $urandom_range(FRAME_PIXELS, LAST_INDEX);
            queue_word($urandom_range(0, 1) ? ACT_PROCESS : ACT_LOAD, idx, src, bg);
        end
        else
        begin
            if ($urandom_range(0, 6) == 0)
                idx = $urandom_range(0, FRAME_PIXELS - 1);
            else
                idx = hot_pixels[$urandom_range(0, HOT_COUNT - 1)];
            // never process a pixel that has not been loaded
            if (r < 30 || !loaded.exists(idx))
                queue_word(ACT_LOAD, idx, src, bg);
            else
                queue_word(ACT_PROCESS, idx, src, bg);
        end
    endtask

    initial
    begin
        int m;
        int f;
        int b;
        int d;
        move_thr      = int'(MOVE_THRESHOLD_RST);
        flicker_thr   = int'(FLICKER_THRESHOLD_RST);
        brighten_gain = int'(BRIGHTEN_GAIN_RST);
        darken_gain   = int'(DARKEN_GAIN_RST);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // exact zero and exact full scale, flicker floor, equal pixels, off-frame indexes
        program_regs(0, 0, 4096, 6144);
        queue_word(ACT_LOAD, 0, 0, 3);
        queue_word(ACT_PROCESS, 0, 1, 100);
        queue_word(ACT_LOAD, FRAME_PIXELS - 1, 0, 10);
        queue_word(ACT_PROCESS, FRAME_PIXELS - 1, 255, 0);
        queue_word(ACT_LOAD, 262144, 0, 255);
        queue_word(ACT_PROCESS, 262144, 0, 255);
        queue_word(ACT_PROCESS, 262144, 1, 0);
        queue_word(ACT_LOAD, FRAME_PIXELS, 0, 77);
        queue_word(ACT_PROCESS, LAST_INDEX, 255, 0);
        queue_word(ACT_PROCESS, 0, 50, 50);
        queue_word(ACT_PROCESS, FRAME_PIXELS - 1, 0, 255);
        wait_drained();

        // thresholds at the top: nothing counts as motion
        program_regs(255, 255, 8191, 0);
        queue_word(ACT_PROCESS, FRAME_PIXELS - 1, 255, 0);
        queue_word(ACT_LOAD, 1, 0, 0);
        queue_word(ACT_PROCESS, 1, 200, 0);
        queue_word(ACT_PROCESS, 1, 0, 255);
        wait_drained();

        // oversized brighten gain clamps, flicker just below full scale
        program_regs(0, 254, 8191, 0);
        queue_word(ACT_PROCESS, 1, 255, 0);
        queue_word(ACT_PROCESS, 1, 100, 0);
        queue_word(ACT_LOAD, 2, 0, 128);
        queue_word(ACT_PROCESS, 2, 255, 0);
        queue_word(ACT_PROCESS, 2, 255, 254);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                m = int'(MOVE_THRESHOLD_RST);
                f = int'(FLICKER_THRESHOLD_RST);
                b = int'(BRIGHTEN_GAIN_RST);
                d = int'(DARKEN_GAIN_RST);
            end
            else if (p == 1)
            begin
                m = 0;
                f = 0;
                b = 8191;
                d = 8191;
            end
            else
            begin
                m = pick_threshold();
                f = pick_threshold();
                b = pick_gain();
                d = pick_gain();
            end
            program_regs(m, f, b, d);
            for (int h = 0; h < HOT_COUNT; h++)
                hot_pixels[h] = $urandom_range(0, FRAME_PIXELS - 1);
            hot_pixels[0] = (p % 2 == 0) ? 0 : FRAME_PIXELS - 1;
            for (int n = 0; n < PHASE_WORDS; n++)
                add_random_word();
            wait_drained();
        end

        if (trail_results.size() != 0)
            report_mismatch("results never seen", 0, trail_results.size());
        $display("%0d words sent (%0d loads, %0d off-frame), %0d results checked",
                 words_sent, loads_sent, off_frame, results_seen);
        $display("%0d motion updates over %0d register settings, %0d errors",
                 motion_hits, PHASES + 3, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
